// ===== rtl/core/arcc_pkg.sv =====
`default_nettype none

package arcc_pkg;

	// Working width of the fixed-point base and midpoint terms.
	localparam int BW = 48;
	// Quotient bits kept by the divider. Anything at or above 2^41 overflows.
	localparam int QW = 41;
	// Width of one result coordinate.
	localparam int OW = 32;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DEGEN = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	// Per-item sideband that rides alongside the division.
	typedef struct packed {
		logic                 circ;
		logic                 degen;
		logic                 neg_x;
		logic                 neg_y;
		logic                 ovf_x;
		logic                 ovf_y;
		logic signed [BW-1:0] base_x;
		logic signed [BW-1:0] base_y;
		logic signed [BW-1:0] mid_x;
		logic signed [BW-1:0] mid_y;
	} meta_t;

endpackage

`default_nettype wire

// ===== rtl/core/arcc_front.sv =====
`default_nettype none

module arcc_front #(
	parameter int CB = 16,
	parameter int FB = 8,
	localparam int DW = CB + 1,
	localparam int PW = 2 * DW,
	localparam int SW = 2 * DW + 1,
	localparam int DENW = 2 * DW + 2,
	localparam int DMW = DENW - 1,
	localparam int MUW = DW + SW,
	localparam int NW = MUW + 1,
	localparam int NMW = (NW + FB > arcc_pkg::QW) ? NW + FB : arcc_pkg::QW + 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  v_i,
	input  wire logic signed [CB-1:0]  p0_x,
	input  wire logic signed [CB-1:0]  p0_y,
	input  wire logic signed [CB-1:0]  p1_x,
	input  wire logic signed [CB-1:0]  p1_y,
	input  wire logic signed [CB-1:0]  p2_x,
	input  wire logic signed [CB-1:0]  p2_y,
	output logic                       v_o,
	output arcc_pkg::meta_t            meta_o,
	output logic [DMW-1:0]             dmag_o,
	output logic [NMW-1:0]             nmx_o,
	output logic [NMW-1:0]             nmy_o
);
	import arcc_pkg::*;

	logic [5:0] v_q;

	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	meta_t meta_d1, meta_d6;
	logic signed [DW-1:0] bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [PW-1:0] pbc_s2, pbyc_s2, bxx_s2, byy_s2, cxx_s2, cyy_s2;
	logic signed [DW-1:0] bx_s2, by_s2, cx_s2, cy_s2;
	logic signed [DENW-1:0] den_s3, den_s4, den_s5;
	logic signed [SW-1:0] sb_s3, sc_s3;
	logic signed [DW-1:0] bx_s3, by_s3, cx_s3, cy_s3;
	logic signed [MUW-1:0] m1_s4, m2_s4, m3_s4, m4_s4;
	logic signed [NW-1:0] nx_s5, ny_s5;
	logic [DMW-1:0] dmag_s6;
	logic [NMW-1:0] nmx_s6, nmy_s6;

	logic [NW-1:0] magx, magy;
	logic [DENW-1:0] dabs;

	assign magx = nx_s5[NW-1] ? -nx_s5 : nx_s5;
	assign magy = ny_s5[NW-1] ? -ny_s5 : ny_s5;
	assign dabs = den_s5[DENW-1] ? -den_s5 : den_s5;

	// sideband for the first stage
	always_comb begin
		meta_d1        = '0;
		meta_d1.circ   = (p0_x == p2_x) && (p0_y == p2_y);
		meta_d1.base_x = BW'(p0_x) <<< FB;
		meta_d1.base_y = BW'(p0_y) <<< FB;
		meta_d1.mid_x  = (BW'(p0_x) + BW'(p1_x)) <<< (FB - 1);
		meta_d1.mid_y  = (BW'(p0_y) + BW'(p1_y)) <<< (FB - 1);
	end

	// sideband with zero-divisor and sign flags filled in
	always_comb begin
		meta_d6       = meta_s5;
		meta_d6.degen = (den_s5 == '0);
		meta_d6.neg_x = nx_s5[NW-1] ^ den_s5[DENW-1];
		meta_d6.neg_y = ny_s5[NW-1] ^ den_s5[DENW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[4:0], v_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// differences and sideband
			bx_s1 <= DW'(p1_x) - DW'(p0_x);
			by_s1 <= DW'(p1_y) - DW'(p0_y);
			cx_s1 <= DW'(p2_x) - DW'(p0_x);
			cy_s1 <= DW'(p2_y) - DW'(p0_y);
			meta_s1 <= meta_d1;

			// cross and square products
			pbc_s2  <= bx_s1 * cy_s1;
			pbyc_s2 <= by_s1 * cx_s1;
			bxx_s2  <= bx_s1 * bx_s1;
			byy_s2  <= by_s1 * by_s1;
			cxx_s2  <= cx_s1 * cx_s1;
			cyy_s2  <= cy_s1 * cy_s1;
			bx_s2 <= bx_s1;
			by_s2 <= by_s1;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			meta_s2 <= meta_s1;

			// divisor and squared lengths
			den_s3 <= (DENW'(pbc_s2) - DENW'(pbyc_s2)) <<< 1;
			sb_s3  <= SW'(bxx_s2) + SW'(byy_s2);
			sc_s3  <= SW'(cxx_s2) + SW'(cyy_s2);
			bx_s3 <= bx_s2;
			by_s3 <= by_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
			meta_s3 <= meta_s2;

			// weighted numerator terms
			m1_s4 <= MUW'(cy_s3) * MUW'(sb_s3);
			m2_s4 <= MUW'(by_s3) * MUW'(sc_s3);
			m3_s4 <= MUW'(bx_s3) * MUW'(sc_s3);
			m4_s4 <= MUW'(cx_s3) * MUW'(sb_s3);
			den_s4  <= den_s3;
			meta_s4 <= meta_s3;

			nx_s5 <= NW'(m1_s4) - NW'(m2_s4);
			ny_s5 <= NW'(m3_s4) - NW'(m4_s4);
			den_s5  <= den_s4;
			meta_s5 <= meta_s4;

			// sign-magnitude split, scale numerators by the fraction bits
			nmx_s6  <= NMW'(magx) << FB;
			nmy_s6  <= NMW'(magy) << FB;
			dmag_s6 <= dabs[DMW-1:0];
			meta_s6 <= meta_d6;
		end
	end

	assign v_o    = v_q[5];
	assign meta_o = meta_s6;
	assign dmag_o = dmag_s6;
	assign nmx_o  = nmx_s6;
	assign nmy_o  = nmy_s6;

endmodule

`default_nettype wire

// ===== rtl/core/arcc_div.sv =====
`default_nettype none

module arcc_div #(
	parameter int DMW = 35,
	parameter int NMW = 61,
	localparam int HW = NMW - arcc_pkg::QW,
	localparam int CW = (HW > DMW) ? HW : DMW
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   v_i,
	input  wire arcc_pkg::meta_t        meta_i,
	input  wire logic [DMW-1:0]         dmag_i,
	input  wire logic [NMW-1:0]         nmx_i,
	input  wire logic [NMW-1:0]         nmy_i,
	output logic                        v_o,
	output arcc_pkg::meta_t             meta_o,
	output logic [arcc_pkg::QW-1:0]     qx_o,
	output logic [arcc_pkg::QW-1:0]     qy_o,
	output logic                        rnzx_o,
	output logic                        rnzy_o
);
	import arcc_pkg::*;

	logic [QW:0] v_q;
	meta_t meta_s [QW+1];
	logic [DMW-1:0] d_s [QW+1];
	logic [DMW-1:0] rx_s [QW+1];
	logic [DMW-1:0] ry_s [QW+1];
	logic [QW-1:0] qx_s [QW+1];
	logic [QW-1:0] qy_s [QW+1];

	logic [HW-1:0] hix, hiy;
	meta_t meta_d0;

	// Upper numerator bits: if they already reach the divisor, the
	// quotient is at least 2^41 and the axis overflows.
	assign hix = nmx_i[NMW-1:QW];
	assign hiy = nmy_i[NMW-1:QW];

	always_comb begin
		meta_d0       = meta_i;
		meta_d0.ovf_x = CW'(hix) >= CW'(dmag_i);
		meta_d0.ovf_y = CW'(hiy) >= CW'(dmag_i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[QW-1:0], v_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0] <= meta_d0;
			d_s[0]  <= dmag_i;
			rx_s[0] <= DMW'(hix);
			ry_s[0] <= DMW'(hiy);
			qx_s[0] <= nmx_i[QW-1:0];
			qy_s[0] <= nmy_i[QW-1:0];
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [DMW:0] r2x, r2y, dfx, dfy;
		logic gex, gey;

		// shift in next numerator bit, try subtract
		assign r2x = {rx_s[k-1], qx_s[k-1][QW-1]};
		assign r2y = {ry_s[k-1], qy_s[k-1][QW-1]};
		assign dfx = r2x - {1'b0, d_s[k-1]};
		assign dfy = r2y - {1'b0, d_s[k-1]};
		assign gex = r2x >= {1'b0, d_s[k-1]};
		assign gey = r2y >= {1'b0, d_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k]   <= gex ? dfx[DMW-1:0] : r2x[DMW-1:0];
				ry_s[k]   <= gey ? dfy[DMW-1:0] : r2y[DMW-1:0];
				qx_s[k]   <= {qx_s[k-1][QW-2:0], gex};
				qy_s[k]   <= {qy_s[k-1][QW-2:0], gey};
				d_s[k]    <= d_s[k-1];
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	assign v_o    = v_q[QW];
	assign meta_o = meta_s[QW];
	assign qx_o   = qx_s[QW];
	assign qy_o   = qy_s[QW];
	assign rnzx_o = (rx_s[QW] != '0);
	assign rnzy_o = (ry_s[QW] != '0);

endmodule

`default_nettype wire

// ===== rtl/core/arcc_back.sv =====
`default_nettype none

module arcc_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      v_i,
	input  wire arcc_pkg::meta_t           meta_i,
	input  wire logic [arcc_pkg::QW-1:0]   qx_i,
	input  wire logic [arcc_pkg::QW-1:0]   qy_i,
	input  wire logic                      rnzx_i,
	input  wire logic                      rnzy_i,
	output logic                           v_o,
	output logic signed [arcc_pkg::OW-1:0] center_x,
	output logic signed [arcc_pkg::OW-1:0] center_y,
	output arcc_pkg::status_t              status
);
	import arcc_pkg::*;

	localparam logic [QW:0] QLIM = (QW + 1)'(1) << (QW - 1);
	localparam logic signed [BW-1:0] OMAX = {{(BW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
	localparam logic signed [BW-1:0] OMIN = {{(BW - OW + 1){1'b1}}, {(OW - 1){1'b0}}};

	logic v_s1;
	meta_t meta_s1;
	logic [QW:0] q1x_s1, q1y_s1;
	logic bigx_s1, bigy_s1;

	logic [QW:0] q1x, q1y;
	logic signed [BW-1:0] sx, sy, cx, cy;
	logic satx, saty;

	// floor rounding: bump magnitude when the result is negative and inexact
	assign q1x = (QW + 1)'(qx_i) + (QW + 1)'(meta_i.neg_x && rnzx_i);
	assign q1y = (QW + 1)'(qy_i) + (QW + 1)'(meta_i.neg_y && rnzy_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= meta_i;
			q1x_s1  <= q1x;
			q1y_s1  <= q1y;
			bigx_s1 <= meta_i.ovf_x || (q1x > QLIM);
			bigy_s1 <= meta_i.ovf_y || (q1y > QLIM);
		end
	end

	assign sx = meta_s1.neg_x ? meta_s1.base_x - $signed(BW'(q1x_s1))
		: meta_s1.base_x + $signed(BW'(q1x_s1));
	assign sy = meta_s1.neg_y ? meta_s1.base_y - $signed(BW'(q1y_s1))
		: meta_s1.base_y + $signed(BW'(q1y_s1));

	always_comb begin
		cx   = sx;
		cy   = sy;
		satx = 1'b0;
		saty = 1'b0;
		if (meta_s1.circ) begin
			cx = meta_s1.mid_x;
			cy = meta_s1.mid_y;
		end else if (bigx_s1) begin
			cx   = meta_s1.neg_x ? OMIN : OMAX;
			satx = 1'b1;
		end
		if (!meta_s1.circ && bigy_s1) begin
			cy   = meta_s1.neg_y ? OMIN : OMAX;
			saty = 1'b1;
		end
		if (cx > OMAX) begin
			cx   = OMAX;
			satx = 1'b1;
		end else if (cx < OMIN) begin
			cx   = OMIN;
			satx = 1'b1;
		end
		if (cy > OMAX) begin
			cy   = OMAX;
			saty = 1'b1;
		end else if (cy < OMIN) begin
			cy   = OMIN;
			saty = 1'b1;
		end
		priority if (meta_s1.circ) begin
			status = (satx || saty) ? ST_SAT : ST_OK;
		end else if (meta_s1.degen) begin
			cx     = '0;
			cy     = '0;
			status = ST_DEGEN;
		end else begin
			status = (satx || saty) ? ST_SAT : ST_OK;
		end
	end

	assign v_o      = v_s1;
	assign center_x = cx[OW-1:0];
	assign center_y = cy[OW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/arc_circumcenter.sv =====
// Circumcenter of three arc points. Each input beat carries three points with
// signed COORD_BITS-wide integer coordinates; each output beat carries the
// center of the circle through them in signed 32-bit fixed point with
// FRAC_BITS fraction bits, rounded toward minus infinity, plus a status:
// ok, degenerate (collinear or repeated points; center reads zero) or
// saturated (a coordinate clamped to the 32-bit limits; the other one is
// still exact if it fits). When the start and end points coincide the arc
// is taken as a full circle and the center is the midpoint of the first two
// points. The block takes one beat per clock unless a finished beat waits
// on a full, stalled output register. It is built from six arithmetic
// stages (differences, products, divisor and squared lengths, numerator
// products, numerator sums, sign split), one divider setup stage, the
// 41-stage restoring divider that produces one quotient bit per stage for
// both axes, one rounding stage and the output register. The divider depth
// dominates the latency. A stalled output holds its beat; the whole pipeline
// advances together and new beats are still taken while its last stage is empty.
`default_nettype none

module arc_circumcenter #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_BITS-1:0]  p0_x,
	input  wire logic signed [COORD_BITS-1:0]  p0_y,
	input  wire logic signed [COORD_BITS-1:0]  p1_x,
	input  wire logic signed [COORD_BITS-1:0]  p1_y,
	input  wire logic signed [COORD_BITS-1:0]  p2_x,
	input  wire logic signed [COORD_BITS-1:0]  p2_y,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [arcc_pkg::OW-1:0]     center_x,
	output logic signed [arcc_pkg::OW-1:0]     center_y,
	output arcc_pkg::status_t                  status
);
	import arcc_pkg::*;

	// Derived widths; must track the ones inside the front end.
	localparam int DW = COORD_BITS + 1;
	localparam int DMW = 2 * DW + 1;
	localparam int NW = 3 * DW + 2;
	localparam int NMW = (NW + FRAC_BITS > QW) ? NW + FRAC_BITS : QW + 1;

	logic en;
	logic fv, dv, bv;
	meta_t fmeta, dmeta;
	logic [DMW-1:0] dmag;
	logic [NMW-1:0] nmx, nmy;
	logic [QW-1:0] qx, qy;
	logic rnzx, rnzy;
	logic signed [OW-1:0] bcx, bcy;
	status_t bst;

	// Advance the whole pipeline unless a finished beat would land on a
	// full, stalled output register.
	assign en       = !bv || !out_valid || out_ready;
	assign in_ready = en;

	arcc_front #(
		.CB (COORD_BITS),
		.FB (FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (in_valid),
		.p0_x   (p0_x),
		.p0_y   (p0_y),
		.p1_x   (p1_x),
		.p1_y   (p1_y),
		.p2_x   (p2_x),
		.p2_y   (p2_y),
		.v_o    (fv),
		.meta_o (fmeta),
		.dmag_o (dmag),
		.nmx_o  (nmx),
		.nmy_o  (nmy)
	);

	arcc_div #(
		.DMW (DMW),
		.NMW (NMW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (fv),
		.meta_i (fmeta),
		.dmag_i (dmag),
		.nmx_i  (nmx),
		.nmy_i  (nmy),
		.v_o    (dv),
		.meta_o (dmeta),
		.qx_o   (qx),
		.qy_o   (qy),
		.rnzx_o (rnzx),
		.rnzy_o (rnzy)
	);

	arcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_i      (dv),
		.meta_i   (dmeta),
		.qx_i     (qx),
		.qy_i     (qy),
		.rnzx_i   (rnzx),
		.rnzy_i   (rnzy),
		.v_o      (bv),
		.center_x (bcx),
		.center_y (bcy),
		.status   (bst)
	);

	// Output register: drop the beat once taken, load a new one when it arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (en && bv) begin
				out_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && bv) begin
			center_x <= bcx;
			center_y <= bcy;
			status   <= bst;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/arcc_checker.sv =====
`default_nettype none

module arcc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic signed [arcc_pkg::OW-1:0] center_x,
	input wire logic signed [arcc_pkg::OW-1:0] center_y,
	input wire arcc_pkg::status_t             status
);
	import arcc_pkg::*;

	localparam logic signed [OW-1:0] CMAX = {1'b0, {(OW - 1){1'b1}}};
	localparam logic signed [OW-1:0] CMIN = {1'b1, {(OW - 1){1'b0}}};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(center_x)
			&& $stable(center_y) && $stable(status))
		else $error("stalled result beat changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_DEGEN || status == ST_SAT))
		else $error("status code out of range");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DEGEN |-> center_x == '0 && center_y == '0)
		else $error("degenerate result with nonzero center");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SAT |-> center_x == CMAX || center_x == CMIN
			|| center_y == CMAX || center_y == CMIN)
		else $error("saturated status without a clamped coordinate");

endmodule

bind arc_circumcenter arcc_checker u_arcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.center_x  (center_x),
	.center_y  (center_y),
	.status    (status)
);

`default_nettype wire

// ===== bench/arc_circumcenter_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module arc_circumcenter_tb;
	import arcc_pkg::*;

	localparam int CB = 16;
	localparam int FB = 8;
	localparam int N_RANDOM = 630;
	localparam int QUIET_FROM = 540;
	localparam int LATENCY = 50;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [OW-1:0] cx;
		logic signed [OW-1:0] cy;
		status_t st;
	} center_t;

	// Keeps the centers owed by the block, oldest first.
	class center_board;
		center_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// floor(base + num / den) in fixed point; set sat when it leaves 32 bits
		function longint axis(longint base, logic signed [127:0] num, longint den,
				inout bit sat);
			logic [127:0] mag, dmag, q, r;
			bit neg;
			longint v;
			neg = num[127] ^ (den < 0);
			mag = num[127] ? -num : num;
			mag = mag << FB;
			dmag = (den < 0) ? -den : den;
			q = mag / dmag;
			r = mag % dmag;
			if (neg && r != 0)
				q = q + 1;
			if (q > (128'd1 << 40)) begin
				sat = 1;
				return neg ? -64'sd2147483648 : 64'sd2147483647;
			end
			v = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
			v = base * (64'sd1 << FB) + v;
			return clamp(v, sat);
		endfunction

		function longint clamp(longint v, inout bit sat);
			if (v > 64'sd2147483647) begin
				sat = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				sat = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		// Work out the center for one accepted point triple.
		function void note_points(logic signed [CB-1:0] ax, ay, bxi, byi, cxi, cyi);
			longint x0, y0, x1, y1, x2, y2, bx, by, cx, cy, den, sb, sc;
			logic signed [127:0] nx, ny;
			center_t e;
			bit sat;
			x0 = ax; y0 = ay; x1 = bxi; y1 = byi; x2 = cxi; y2 = cyi;
			sat = 0;
			e.cx = 0;
			e.cy = 0;
			if (x0 == x2 && y0 == y2) begin
				e.cx = OW'(clamp((x0 + x1) * (64'sd1 << (FB - 1)), sat));
				e.cy = OW'(clamp((y0 + y1) * (64'sd1 << (FB - 1)), sat));
				e.st = sat ? ST_SAT : ST_OK;
			end else begin
				bx = x1 - x0; by = y1 - y0;
				cx = x2 - x0; cy = y2 - y0;
				den = 2 * (bx * cy - by * cx);
				if (den == 0) begin
					e.st = ST_DEGEN;
				end else begin
					sb = bx * bx + by * by;
					sc = cx * cx + cy * cy;
					nx = 128'(signed'(cy)) * 128'(signed'(sb))
						- 128'(signed'(by)) * 128'(signed'(sc));
					ny = 128'(signed'(bx)) * 128'(signed'(sc))
						- 128'(signed'(cx)) * 128'(signed'(sb));
					e.cx = OW'(axis(x0, nx, den, sat));
					e.cy = OW'(axis(y0, ny, den, sat));
					e.st = sat ? ST_SAT : ST_OK;
				end
			end
			pending.push_back(e);
		endfunction

		// Compare one output beat with the oldest owed center.
		function void check_center(logic signed [OW-1:0] cx, cy, logic [1:0] st);
			center_t e;
			if (pending.size() == 0) begin
				$error("output beat with no center owed");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (cx !== e.cx) begin
				$error("center_x expected %0d actual %0d", e.cx, cx);
				errors++;
			end
			if (cy !== e.cy) begin
				$error("center_y expected %0d actual %0d", e.cy, cy);
				errors++;
			end
			if (st !== e.st) begin
				$error("status expected %0d actual %0d", e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [CB-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y;
	logic out_valid;
	logic out_ready;
	logic signed [OW-1:0] center_x, center_y;
	status_t status;

	center_board board;
	bit quiet;
	int cycles;

	arc_circumcenter #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.p0_x(p0_x),
		.p0_y(p0_y),
		.p1_x(p1_x),
		.p1_y(p1_y),
		.p2_x(p2_x),
		.p2_y(p2_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.center_x(center_x),
		.center_y(center_y),
		.status(status)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Offer one point triple and hold it until the block takes the beat.
	task automatic send_points(logic signed [CB-1:0] ax, ay, bx, by, cx, cy);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		p0_x <= ax; p0_y <= ay;
		p1_x <= bx; p1_y <= by;
		p2_x <= cx; p2_y <= cy;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		board.note_points(ax, ay, bx, by, cx, cy);
	endtask

	function automatic logic signed [CB-1:0] small_coord();
		return CB'($signed(CB'($urandom_range(0, 64))) - 32);
	endfunction

	// Draw one random triple; most are well formed, some hit the corner cases.
	task automatic send_random();
		logic signed [CB-1:0] c[6];
		logic signed [CB:0] mx, my;
		int kind;
		kind = $urandom_range(0, 99);
		foreach (c[i]) c[i] = CB'($urandom);
		if (kind < 25) begin
			foreach (c[i]) c[i] = small_coord();
		end else if (kind < 35) begin
			// full circle: end on the start point
			c[4] = c[0]; c[5] = c[1];
		end else if (kind < 45) begin
			// collinear: step from p0 once and three times along the same small vector
			c[0] = CB'(small_coord() * 100); c[1] = CB'(small_coord() * 100);
			mx = small_coord(); my = small_coord();
			c[2] = CB'(c[0] + mx); c[3] = CB'(c[1] + my);
			c[4] = CB'(c[0] + 3 * mx); c[5] = CB'(c[1] + 3 * my);
		end else if (kind < 50) begin
			// repeated middle point
			if ($urandom_range(0, 1)) begin
				c[2] = c[0]; c[3] = c[1];
			end else begin
				c[2] = c[4]; c[3] = c[5];
			end
		end else if (kind < 62) begin
			// nearly collinear: middle point just off the chord, far center
			mx = (c[0] + c[4]) >>> 1;
			my = (c[1] + c[5]) >>> 1;
			c[2] = CB'(CB'(mx) + $signed(CB'($urandom_range(0, 2))) - 1);
			c[3] = CB'(CB'(my) + $signed(CB'($urandom_range(0, 2))) - 1);
		end
		send_points(c[0], c[1], c[2], c[3], c[4], c[5]);
	endtask

	// Stall the output side in bursts until the quiet tail.
	initial begin
		int stall;
		out_ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 6);
				out_ready <= 0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_center(center_x, center_y, status);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	localparam logic signed [CB-1:0] MX = 16'sh7fff;
	localparam logic signed [CB-1:0] MN = -16'sh8000;

	initial begin
		board = new();
		quiet = 0;
		cycles = 0;
		arst_n = 0;
		in_valid = 0;
		p0_x = 0; p0_y = 0; p1_x = 0; p1_y = 0; p2_x = 0; p2_y = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, full circles, degenerate and saturating triples.
		send_points(0, 0, 0, 0, 0, 0);
		send_points(MX, MX, MX, MX, MX, MX);
		send_points(MN, MN, MN, MN, MN, MN);
		send_points(MN, MN, MN, MN, MX, MX);
		send_points(MN, MN, MX, MX, MN, MN);
		send_points(MX, MN, MN, MX, MX, MN);
		send_points(MN, 0, 0, MX, MX, 0);
		send_points(MN, MN, MX, MN, MX, MX);
		send_points(MX, MX, MN, MX, MN, MN);
		send_points(0, 0, 4, 0, 0, 4);
		send_points(0, 0, 1, 1, 2, 2);
		send_points(MN, MN, 0, 0, MX, MX);
		send_points(5, 7, 5, 7, 9, 1);
		send_points(5, 7, 9, 1, 9, 1);
		send_points(MN, 0, 0, 1, MX, 0);
		send_points(MN, 0, 0, -1, MX, 0);
		send_points(0, MN, 1, 0, 0, MX);
		send_points(0, MN, -1, 0, 0, MX);
		send_points(MN, MN, -1, 0, MX, MX);
		send_points(3, -2, -7, 11, -5, -9);
		send_points(-1, -1, 1, 1, -1, 1);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == QUIET_FROM)
				quiet = 1;
			send_random();
		end
		in_valid <= 0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		if (board.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
